>>> rtl/ast_pkg.sv
// ----------------------------------------------------------------------------
// ast_pkg: shared types and constants of the alarm slot table
// Field widths, item kinds, and the command and status bundles that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package ast_pkg;

  localparam int SLOTS_DEF   = 16;
  localparam int MAX_RESULTS = 16;
  localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

  localparam int KIND_W      = 2;
  localparam int ID_W        = 32;
  localparam int PERIOD_W    = 16;
  localparam int WORD_W      = ID_W + 2 * PERIOD_W;

  localparam int IN_DATA_W   = 56;
  localparam int OUT_DATA_W  = 72;

  typedef enum logic [KIND_W-1:0] {
    KIND_CREATE = 2'd0,
    KIND_DELETE = 2'd1,
    KIND_TICK   = 2'd2
  } kind_t;

  typedef struct packed {
    logic load;
    logic eval;
    logic push_final;
  } ctl_cmd_t;

  typedef struct packed {
    logic kind_ok;
    logic hit;
    logic stall;
    logic need_push;
    logic out_free;
  } dp_stat_t;

endpackage

>>> rtl/ast_ram.sv
// ----------------------------------------------------------------------------
// ast_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; the read data holds while
// no read is requested.
// ----------------------------------------------------------------------------
module ast_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/ast_ctl.sv
// ----------------------------------------------------------------------------
// ast_ctl: sequencing controller of the alarm slot table
// Accepts one item, walks the slots one per cycle through the datapath while
// no fired result stalls on the output, then hands over the closing result.
// ----------------------------------------------------------------------------
module ast_ctl
  import ast_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEF,
  parameter int IDXW  = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  output logic            s_tready,
  input  dp_stat_t        st,
  output ctl_cmd_t        cmd,
  output logic            rd_en,
  output logic [IDXW-1:0] rd_addr,
  output logic [IDXW-1:0] cur
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_PRIME  = 4'b0010,
    S_WALK   = 4'b0100,
    S_FINISH = 4'b1000
  } state_t;

  localparam logic [IDXW-1:0] LastSlot = IDXW'(SLOTS - 1);

  state_t          state, state_next;
  logic [IDXW-1:0] cur_next;

  assign s_tready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cur_next   = cur;
    cmd        = '0;
    rd_en      = 1'b0;
    rd_addr    = cur;
    case (state)
      S_IDLE: begin
        cur_next = '0;
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = S_PRIME;
        end
      end
      S_PRIME: begin
        if (st.kind_ok) begin
          rd_en      = 1'b1;
          state_next = S_WALK;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_WALK: begin
        if (!st.stall) begin
          cmd.eval = 1'b1;
          if (st.hit || (cur == LastSlot)) begin
            state_next = S_FINISH;
          end else begin
            rd_en    = 1'b1;
            rd_addr  = cur + IDXW'(1);
            cur_next = cur + IDXW'(1);
          end
        end
      end
      S_FINISH: begin
        if (!st.need_push) begin
          state_next = S_IDLE;
        end else if (st.out_free) begin
          cmd.push_final = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cur   <= '0;
    end else begin
      state <= state_next;
      cur   <= cur_next;
    end
  end

  // The walk is only entered after the first slot read has been issued.
  a_walk_entry: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK) |-> ($past(state) == S_PRIME || $past(state) == S_WALK))
    else $error("slot walk entered without a primed read");

  // The closing result is only handed over from the finish state.
  a_final_push: assert property (@(posedge clk) disable iff (rst)
    cmd.push_final |=> (state == S_IDLE))
    else $error("final result pushed outside the finish step");

endmodule

>>> rtl/ast_dp.sv
// ----------------------------------------------------------------------------
// ast_dp: datapath of the alarm slot table
// Holds the item, the slot flags, the slot RAM (id, period, remaining),
// the id counter, the held fire result and the output register.
// ----------------------------------------------------------------------------
module ast_dp
  import ast_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEF,
  parameter int IDXW  = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [IN_DATA_W-1:0]  s_tdata,
  input  logic [KIND_W-1:0]     s_tuser,
  input  ctl_cmd_t              cmd,
  input  logic                  rd_en,
  input  logic [IDXW-1:0]       rd_addr,
  input  logic [IDXW-1:0]       cur,
  output dp_stat_t              st,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,
  output logic [0:0]            m_tuser,
  output logic                  m_tlast
);

  localparam logic [CNT_W-1:0] MaxCnt = CNT_W'(MAX_RESULTS);

  // Item register.
  kind_t                kind;
  logic [PERIOD_W-1:0]  period_in;
  logic                 periodic_in;
  logic [ID_W-1:0]      id_in;

  // Slot flags and counters.
  logic [SLOTS-1:0]     slot_busy;
  logic [SLOTS-1:0]     slot_periodic;
  logic [ID_W-1:0]      next_ident;
  logic [ID_W-1:0]      ident_inc;
  logic [CNT_W-1:0]     fire_cnt;

  // Create and delete result, held fire result, output register.
  logic                 res_ok;
  logic [ID_W-1:0]      res_id;
  logic                 pend_valid;
  logic [ID_W-1:0]      pend_id;
  logic                 o_ok;
  logic [ID_W-1:0]      o_new_id;
  logic                 o_fired;
  logic [ID_W-1:0]      o_fired_id;

  // Slot RAM port.
  logic                 ram_we;
  logic [WORD_W-1:0]    ram_wdata;
  logic [WORD_W-1:0]    ram_rdata;
  logic [ID_W-1:0]      rd_ident;
  logic [PERIOD_W-1:0]  rd_period;
  logic [PERIOD_W-1:0]  rd_rem;

  logic is_create, is_delete, is_tick;
  logic busy_c, per_c;
  logic c_hit, d_hit, t_active, t_one, t_fire, t_dec;
  logic out_free, push_mid;

  ast_ram #(
    .WIDTH (WORD_W),
    .DEPTH (SLOTS),
    .AW    (IDXW)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cur),
    .wdata (ram_wdata),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  assign rd_ident  = ram_rdata[WORD_W-1 -: ID_W];
  assign rd_period = ram_rdata[2*PERIOD_W-1 -: PERIOD_W];
  assign rd_rem    = ram_rdata[PERIOD_W-1:0];

  assign is_create = (kind == KIND_CREATE);
  assign is_delete = (kind == KIND_DELETE);
  assign is_tick   = (kind == KIND_TICK);

  assign busy_c = slot_busy[cur];
  assign per_c  = slot_periodic[cur];

  assign c_hit    = !busy_c;
  assign d_hit    = busy_c && (id_in != '0) && (rd_ident == id_in);
  assign t_active = busy_c && (rd_rem != '0);
  assign t_one    = (rd_rem == PERIOD_W'(1));
  // A slot past the per-tick fire limit is left at one for the next tick.
  assign t_fire   = t_active && t_one && (fire_cnt < MaxCnt);
  assign t_dec    = t_active && !t_one;

  assign out_free = !m_tvalid || m_tready;
  assign push_mid = cmd.eval && is_tick && t_fire && pend_valid;

  assign ident_inc = next_ident + ID_W'(1);

  assign st.kind_ok   = is_create || is_delete || is_tick;
  assign st.hit       = (is_create && c_hit) || (is_delete && d_hit);
  assign st.stall     = is_tick && t_fire && pend_valid && !out_free;
  assign st.need_push = is_tick ? pend_valid : 1'b1;
  assign st.out_free  = out_free;

  always_comb begin
    ram_we    = 1'b0;
    ram_wdata = ram_rdata;
    if (cmd.eval) begin
      if (is_create && c_hit) begin
        ram_we    = 1'b1;
        ram_wdata = {next_ident, period_in, period_in};
      end else if (is_tick && t_fire) begin
        ram_we    = 1'b1;
        ram_wdata = {rd_ident, rd_period, per_c ? rd_period : PERIOD_W'(0)};
      end else if (is_tick && t_dec) begin
        ram_we    = 1'b1;
        ram_wdata = {rd_ident, rd_period, rd_rem - PERIOD_W'(1)};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind        <= kind_t'(s_tuser);
      period_in   <= s_tdata[PERIOD_W-1:0];
      periodic_in <= s_tdata[PERIOD_W];
      id_in       <= s_tdata[PERIOD_W+ID_W:PERIOD_W+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_busy     <= '0;
      slot_periodic <= '0;
      next_ident    <= ID_W'(1);
      fire_cnt      <= '0;
      pend_valid    <= 1'b0;
      m_tvalid      <= 1'b0;
    end else begin
      if (cmd.load) begin
        fire_cnt <= '0;
        res_ok   <= 1'b0;
        res_id   <= '0;
      end
      if (cmd.eval) begin
        if (is_create && c_hit) begin
          slot_busy[cur]     <= 1'b1;
          slot_periodic[cur] <= periodic_in;
          res_ok             <= 1'b1;
          res_id             <= next_ident;
          next_ident         <= (ident_inc == '0) ? ID_W'(1) : ident_inc;
        end
        if (is_delete && d_hit) begin
          slot_busy[cur]     <= 1'b0;
          slot_periodic[cur] <= 1'b0;
          res_ok             <= 1'b1;
        end
        if (is_tick && t_fire) begin
          fire_cnt   <= fire_cnt + CNT_W'(1);
          pend_valid <= 1'b1;
          pend_id    <= rd_ident;
          if (!per_c) begin
            slot_busy[cur]     <= 1'b0;
            slot_periodic[cur] <= 1'b0;
          end
        end
      end
      if (push_mid) begin
        m_tvalid   <= 1'b1;
        o_ok       <= 1'b1;
        o_new_id   <= '0;
        o_fired    <= 1'b1;
        o_fired_id <= pend_id;
        m_tlast    <= 1'b0;
      end else if (cmd.push_final) begin
        m_tvalid <= 1'b1;
        m_tlast  <= 1'b1;
        if (is_tick) begin
          pend_valid <= 1'b0;
          o_ok       <= 1'b1;
          o_new_id   <= '0;
          o_fired    <= 1'b1;
          o_fired_id <= pend_id;
        end else begin
          o_ok       <= res_ok;
          o_new_id   <= res_id;
          o_fired    <= 1'b0;
          o_fired_id <= '0;
        end
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  assign m_tdata = {{(OUT_DATA_W - 1 - 2 * ID_W){1'b0}}, o_fired_id, o_new_id, o_ok};
  assign m_tuser = o_fired;

  a_ident_nonzero: assert property (@(posedge clk) disable iff (rst)
    next_ident != '0)
    else $error("id counter reached zero");

  a_fire_limit: assert property (@(posedge clk) disable iff (rst)
    fire_cnt <= MaxCnt)
    else $error("more expiries reported than allowed on one tick");

  a_fire_id: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && o_fired) |-> (o_fired_id != '0))
    else $error("expiry reported with a zero id");

endmodule

>>> rtl/alarm_slot_table.sv
// ----------------------------------------------------------------------------
// alarm_slot_table: table of one-shot and periodic millisecond alarms
// Creates, deletes and ticks a bank of alarm slots; reports expiries.
// ----------------------------------------------------------------------------
// Sequence: an item is accepted in the idle state; a priming step issues the
// first slot RAM read, the walk then visits one slot per cycle while no fired
// result stalls on the output (up to SLOTS slots, a create or delete stops at
// its slot), and a finish step, which waits for the output register to free
// up, closes the item. A new item is accepted only once the previous one is
// closed. An unknown kind goes from the priming step back to idle with no
// result.
// Reset clears the controller, the busy and mode flags, the fire count and
// the id counter (to one); the slot RAM is not cleared and needs no pass.
// ----------------------------------------------------------------------------
module alarm_slot_table
  import ast_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  // Input beats.
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // s_tdata, from bit 0 up: period_ms[15:0], periodic[16], alarm_id[48:17],
  // zero fill to bit 55.
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // s_tuser: kind[1:0] (0 create, 1 delete, 2 tick).
  input  logic [KIND_W-1:0]     s_tuser,
  // Result beats.
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // m_tdata, from bit 0 up: ok[0], new_id[32:1], fired_id[64:33],
  // zero fill to bit 71.
  output logic [OUT_DATA_W-1:0] m_tdata,
  // m_tuser: fired[0].
  output logic [0:0]            m_tuser,
  // m_tlast: last result beat caused by one input beat.
  output logic                  m_tlast
);

  localparam int IDXW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  // Controller to datapath: commands, the slot under evaluation and the
  // RAM read request. Datapath to controller: match, stall and output state.
  ctl_cmd_t        cmd;
  dp_stat_t        st;
  logic            rd_en;
  logic [IDXW-1:0] rd_addr;
  logic [IDXW-1:0] cur;

  ast_ctl #(
    .SLOTS (SLOTS),
    .IDXW  (IDXW)
  ) u_ctl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .st       (st),
    .cmd      (cmd),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .cur      (cur)
  );

  // The datapath holds the single slot RAM; a fired result waits in a
  // holding register until the next one (or the end of the walk) shows
  // whether it is the last beat of the tick.
  ast_dp #(
    .SLOTS (SLOTS),
    .IDXW  (IDXW)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .cmd      (cmd),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .cur      (cur),
    .st       (st),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule
